// ----- rtl/dep_pkg.sv -----
// Package for the directory entry parser.
// Holds the result word type, result kind codes, register indexes and constants.
// No dependencies.
package dep_pkg;

  localparam int unsigned BLK_BYTES_W   = 17;
  localparam int unsigned ENTRY_LIMIT_W = 15;
  localparam int unsigned CFG_DATA_W    = 17;
  localparam int unsigned CFG_INDEX_W   = 1;
  localparam int unsigned HDR_W         = 56;

  localparam logic [7:0] NAME_KEEP = 8'd255;
  localparam logic [15:0] HDR_BYTES = 16'd8;

  localparam logic [BLK_BYTES_W-1:0]   BLK_BYTES_RST   = 17'd4096;
  localparam logic [ENTRY_LIMIT_W-1:0] ENTRY_LIMIT_RST = 15'd16384;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLK_BYTES   = 1'b0,
    REG_ENTRY_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_NAME     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] inode;
    logic [7:0]  type_byte;
    logic [15:0] record_length;
    logic [7:0]  name_length;
    logic [7:0]  name_byte;
    logic        last;
  } result_t;

endpackage

// ----- rtl/directory_entry_parser_top.sv -----
// Top level of the directory entry parser: byte parser plus output skid buffer.
// Depends on dep_pkg and dep_parse.
// A result is registered in the output register, or in the skid register when the output is stalled.
// Throughput: one word per cycle while the output is not stalled; a result that meets a
// stalled output waits in the skid register, which stalls the input until it drains.
// Reset (rst, synchronous) restores the register defaults and clears the parse state apart from the header bytes.
module directory_entry_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [dep_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dep_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            block_start,
  input  logic                            listing_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dep_pkg::kind_t                  kind,
  output logic [31:0]                     inode,
  output logic [7:0]                      type_byte,
  output logic [15:0]                     record_length,
  output logic [7:0]                      name_length,
  output logic [7:0]                      name_byte,
  output logic                            last
);
  import dep_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_word;
  logic    skid_valid;
  result_t skid_word;
  logic    pop;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  dep_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .data_byte     (data_byte),
    .block_start   (block_start),
    .listing_start (listing_start),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= accept && res_valid;
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_word <= skid_word;
      end
    end else if (!out_valid || pop) begin
      out_word <= res;
    end else begin
      skid_word <= res;
    end
  end

  assign kind          = out_word.kind;
  assign inode         = out_word.inode;
  assign type_byte     = out_word.type_byte;
  assign record_length = out_word.record_length;
  assign name_length   = out_word.name_length;
  assign name_byte     = out_word.name_byte;
  assign last          = out_word.last;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without an output word");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(accept && res_valid && out_valid && out_stall))
    else $error("skid filled without a stalled result");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && out_valid && out_stall) |=> skid_valid)
    else $error("result dropped under output stall");

  a_name_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_NAME) |-> (inode == 32'd0 && name_length == 8'd0))
    else $error("name word carries header fields");

endmodule

// ----- rtl/dep_parse.sv -----
// Record parser state and per-byte decode for linear directory blocks.
// Holds the configuration registers and produces at most one result per word.
// Depends on dep_pkg.
module dep_parse (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [dep_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dep_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  logic [7:0]                      data_byte,
  input  logic                            block_start,
  input  logic                            listing_start,
  output logic                            res_valid,
  output dep_pkg::result_t                res
);
  import dep_pkg::*;

  logic [BLK_BYTES_W-1:0]   blk_bytes;
  logic [ENTRY_LIMIT_W-1:0] entry_limit;

  logic [BLK_BYTES_W-1:0]   block_position, block_position_next;
  logic [15:0]              record_offset, record_offset_next;
  logic [HDR_W-1:0]         header_bytes, header_bytes_next;
  logic [7:0]               name_bytes_left, name_bytes_left_next;
  logic                     skip_rest_of_block, skip_rest_of_block_next;
  logic                     overflow_error, overflow_error_next;
  logic [ENTRY_LIMIT_W-1:0] live_count, live_count_next;

  logic                   new_block;
  logic                   active;
  logic [BLK_BYTES_W-1:0] pos_e;
  logic [15:0]            off_e;
  logic [16:0]            off_inc;
  logic [BLK_BYTES_W-1:0] rec_start;
  logic [BLK_BYTES_W:0]   rec_end;
  logic [31:0]            hdr_inode;
  logic [15:0]            hdr_rec_len;
  logic [7:0]             hdr_name_len;
  logic [15:0]            room;
  logic [7:0]             keep_cap;
  logic [7:0]             keep;
  logic                   bad_record;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_bytes   <= BLK_BYTES_RST;
      entry_limit <= ENTRY_LIMIT_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLK_BYTES:   blk_bytes   <= cfg_data[BLK_BYTES_W-1:0];
        REG_ENTRY_LIMIT: entry_limit <= cfg_data[ENTRY_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_position     <= '0;
      record_offset      <= '0;
      name_bytes_left    <= '0;
      skip_rest_of_block <= 1'b0;
      overflow_error     <= 1'b0;
      live_count         <= '0;
    end else if (accept) begin
      block_position     <= block_position_next;
      record_offset      <= record_offset_next;
      name_bytes_left    <= name_bytes_left_next;
      skip_rest_of_block <= skip_rest_of_block_next;
      overflow_error     <= overflow_error_next;
      live_count         <= live_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      header_bytes <= header_bytes_next;
    end
  end

  always_comb begin
    new_block               = block_start | listing_start;
    pos_e                   = new_block ? '0 : block_position;
    off_e                   = new_block ? '0 : record_offset;
    block_position_next     = pos_e;
    record_offset_next      = off_e;
    header_bytes_next       = header_bytes;
    name_bytes_left_next    = new_block ? '0 : name_bytes_left;
    skip_rest_of_block_next = new_block ? 1'b0 : skip_rest_of_block;
    overflow_error_next     = listing_start ? 1'b0 : overflow_error;
    live_count_next         = listing_start ? '0 : live_count;

    hdr_inode    = header_bytes[31:0];
    hdr_rec_len  = header_bytes[47:32];
    hdr_name_len = header_bytes[55:48];
    off_inc      = {1'b0, off_e} + 17'd1;
    rec_start    = pos_e - BLK_BYTES_W'(7);
    rec_end      = {1'b0, rec_start} + {2'b00, hdr_rec_len};
    bad_record   = (hdr_rec_len < HDR_BYTES) || (hdr_rec_len[1:0] != 2'b00) ||
                   (rec_end > {1'b0, blk_bytes});
    room         = hdr_rec_len - HDR_BYTES;
    keep_cap     = (hdr_name_len > NAME_KEEP) ? NAME_KEEP : hdr_name_len;
    keep         = ({8'd0, keep_cap} > room) ? room[7:0] : keep_cap;

    res_valid         = 1'b0;
    res               = '0;
    res.kind          = KIND_HEADER;

    active = !overflow_error_next && (pos_e < blk_bytes);
    if (active) begin
      block_position_next = pos_e + BLK_BYTES_W'(1);
      if (!skip_rest_of_block_next) begin
        if (off_e < HDR_BYTES) begin
          if (off_e[2:0] != 3'd7) begin
            if (off_e[2:0] == 3'd0) begin
              header_bytes_next = {48'd0, data_byte};
            end else begin
              header_bytes_next[8*off_e[2:0] +: 8] = data_byte;
            end
            record_offset_next = off_inc[15:0];
          end else if (bad_record) begin
            skip_rest_of_block_next = 1'b1;
          end else if (hdr_inode != 32'd0) begin
            if (live_count_next >= entry_limit) begin
              overflow_error_next = 1'b1;
              res_valid           = 1'b1;
              res.kind            = KIND_OVERFLOW;
              res.last            = 1'b1;
            end else begin
              live_count_next      = live_count_next + ENTRY_LIMIT_W'(1);
              name_bytes_left_next = keep;
              res_valid            = 1'b1;
              res.kind             = KIND_HEADER;
              res.inode            = hdr_inode;
              res.type_byte        = data_byte;
              res.record_length    = hdr_rec_len;
              res.name_length      = keep;
              res.last             = (keep == 8'd0);
              record_offset_next   = (hdr_rec_len == HDR_BYTES) ? '0 : HDR_BYTES;
            end
          end else begin
            name_bytes_left_next = '0;
            record_offset_next   = (hdr_rec_len == HDR_BYTES) ? '0 : HDR_BYTES;
          end
        end else begin
          if (name_bytes_left_next != 8'd0) begin
            name_bytes_left_next = name_bytes_left_next - 8'd1;
            res_valid            = 1'b1;
            res.kind             = KIND_NAME;
            res.name_byte        = data_byte;
            res.last             = (name_bytes_left_next == 8'd0);
          end
          record_offset_next = (off_inc >= {1'b0, hdr_rec_len}) ? '0 : off_inc[15:0];
        end
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// Testbench for directory_entry_parser_top: streams directory block bytes, predicts the
// header, name and overflow words in a byte-level parser model and checks every output word.
// Depends on dep_pkg and the RTL of directory_entry_parser_top.
module tb;
  import dep_pkg::*;

  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 4;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_TOGGLE,
    RX_HEAVY
  } rx_mode_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_write_en  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic [7:0]             data_byte     = 8'h00;
  logic                   block_start   = 1'b0;
  logic                   listing_start = 1'b0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  kind_t                  kind;
  logic [31:0]            inode;
  logic [7:0]             type_byte;
  logic [15:0]            record_length;
  logic [7:0]             name_length;
  logic [7:0]             name_byte;
  logic                   last;

  directory_entry_parser_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .block_start   (block_start),
    .listing_start (listing_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .inode         (inode),
    .type_byte     (type_byte),
    .record_length (record_length),
    .name_length   (name_length),
    .name_byte     (name_byte),
    .last          (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser model state and configuration.
  logic [BLK_BYTES_W-1:0]   blk_size;
  logic [ENTRY_LIMIT_W-1:0] max_ent;
  logic [16:0]              blk_pos;
  logic [15:0]              rec_off;
  logic [63:0]              hdr;
  logic [7:0]               name_left;
  logic                     skip_blk;
  logic                     ovf;
  logic [14:0]              n_entries;

  result_t     due_words[$];
  int unsigned fails       = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned burst_left  = 0;
  bit          no_gaps     = 1'b0;
  logic        next_bs     = 1'b0;
  logic        next_ls     = 1'b0;

  int unsigned hold_asks    = 0;
  int unsigned hold_done    = 0;
  int unsigned hold_left    = 0;
  int unsigned stretch_left = 0;
  rx_mode_t    rx_mode      = RX_FREE;

  function automatic void open_block();
    blk_pos   = '0;
    rec_off   = '0;
    hdr       = '0;
    name_left = '0;
    skip_blk  = 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic bs, input logic ls);
    int unsigned pos;
    int unsigned rlen;
    int unsigned keep;
    logic [31:0] ino;
    result_t     r;
    if (ls) begin
      n_entries = '0;
      ovf       = 1'b0;
      open_block();
    end else if (bs) begin
      open_block();
    end
    if (ovf || blk_pos >= blk_size) return;
    pos     = blk_pos;
    blk_pos = blk_pos + 1'b1;
    if (skip_blk) return;
    if (rec_off < HDR_BYTES) begin
      if (rec_off == 0) hdr = '0;
      hdr[rec_off*8 +: 8] = b;
      if (rec_off < HDR_BYTES - 1) begin
        rec_off = rec_off + 1'b1;
        return;
      end
      ino  = hdr[31:0];
      rlen = hdr[47:32];
      pos  = pos - 7;
      if (rlen < 8 || (rlen % 4) != 0 || pos + rlen > blk_size) begin
        skip_blk = 1'b1;
        return;
      end
      if (ino != 0) begin
        if (n_entries >= max_ent) begin
          ovf    = 1'b1;
          r      = '0;
          r.kind = KIND_OVERFLOW;
          r.last = 1'b1;
          due_words.push_back(r);
          return;
        end
        n_entries = n_entries + 1'b1;
        keep = hdr[55:48];
        if (keep > NAME_KEEP) keep = NAME_KEEP;
        if (keep > rlen - 8) keep = rlen - 8;
        name_left       = keep[7:0];
        r               = '0;
        r.kind          = KIND_HEADER;
        r.inode         = ino;
        r.type_byte     = hdr[63:56];
        r.record_length = rlen[15:0];
        r.name_length   = name_left;
        r.last          = (name_left == 0);
        due_words.push_back(r);
      end else begin
        name_left = '0;
      end
      rec_off = (rlen == 8) ? 16'd0 : HDR_BYTES;
      return;
    end
    rlen = hdr[47:32];
    if (name_left > 0) begin
      name_left   = name_left - 1'b1;
      r           = '0;
      r.kind      = KIND_NAME;
      r.name_byte = b;
      r.last      = (name_left == 0);
      due_words.push_back(r);
    end
    rec_off = rec_off + 1'b1;
    if (rec_off >= rlen) rec_off = '0;
  endtask

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) parse_byte(data_byte, block_start, listing_start);
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $error("output word with nothing expected: kind %0d", kind);
          fails++;
        end else begin
          want = due_words.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("inode", want.inode, inode);
          check_field("type_byte", 32'(want.type_byte), 32'(type_byte));
          check_field("record_length", 32'(want.record_length), 32'(record_length));
          check_field("name_length", 32'(want.name_length), 32'(name_length));
          check_field("name_byte", 32'(want.name_byte), 32'(name_byte));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_asks != hold_done) begin
      hold_done <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        stretch_left <= $urandom_range(10, 80);
      end else begin
        stretch_left <= stretch_left - 1;
      end
      case (rx_mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        RX_TOGGLE: out_stall <= ~out_stall;
        default:   out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    in_valid      <= 1'b1;
    data_byte     <= b;
    block_start   <= next_bs;
    listing_start <= next_ls;
    next_bs = 1'b0;
    next_ls = 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 25);
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned bsz, input int unsigned ment);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_BLK_BYTES;
    cfg_data     <= CFG_DATA_W'(bsz);
    @(posedge clk);
    cfg_index    <= REG_ENTRY_LIMIT;
    cfg_data     <= CFG_DATA_W'(ment);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    blk_size = BLK_BYTES_W'(bsz);
    max_ent  = ENTRY_LIMIT_W'(ment);
    @(posedge clk);
  endtask

  task automatic send_record();
    logic [31:0] ino;
    logic [7:0]  nlen;
    logic [7:0]  ftype;
    int unsigned rlen;
    int unsigned body;
    int unsigned pick;
    ino  = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 2) ino = '0;
    else if (pick == 2) ino = '1;
    nlen  = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(128, 255))
                                         : 8'($urandom_range(0, 12));
    ftype = 8'($urandom_range(0, 255));
    rlen  = 8 + ((nlen + 3) / 4) * 4 + 4 * $urandom_range(0, 2);
    pick  = $urandom_range(0, 11);
    // The first choice keeps the record's name room no larger than the name, so the name may be clipped.
    if (pick == 0) rlen = 8 + 4 * $urandom_range(0, nlen / 4);
    else if (pick == 1) rlen = $urandom_range(0, 7);
    else if (pick == 2) rlen = rlen + $urandom_range(1, 3);
    else if (pick == 3) rlen = $urandom_range(0, 65535);
    push_byte(ino[7:0]);
    push_byte(ino[15:8]);
    push_byte(ino[23:16]);
    push_byte(ino[31:24]);
    push_byte(rlen[7:0]);
    push_byte(rlen[15:8]);
    push_byte(nlen);
    push_byte(ftype);
    if (rlen >= 8 && (rlen % 4) == 0 && rlen <= 300) body = rlen - 8;
    else body = $urandom_range(0, 6);
    repeat (body) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_block(input int unsigned ls_odds);
    next_bs = 1'b1;
    next_ls = ($urandom_range(1, ls_odds) == 1);
    if (next_ls && $urandom_range(0, 1) == 1) next_bs = 1'b0;
    repeat ($urandom_range(1, 5)) send_record();
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_traffic(input int unsigned goal, input int unsigned ls_odds);
    int unsigned start;
    start = bytes_sent;
    send_block(1);
    while (bytes_sent - start < goal) send_block(ls_odds);
  endtask

  task automatic test_directed_parse();
    logic [7:0] seq[$];
    // Parsing starts without a block start; the name is clipped to the record.
    seq = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0C, 8'h00, 8'h09, 8'hFF,
            8'h00, 8'hFF, 8'h5A, 8'hA5};
    foreach (seq[i]) push_byte(seq[i]);
    wait_idle();
    // A tiny block with no room for entries: an empty record, a short tail, bytes past
    // the end, and then a live entry that overflows at once.
    set_config(12, 0);
    next_ls = 1'b1;
    seq = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00,
            8'h01, 8'h00, 8'h00, 8'h00, 8'hAA};
    foreach (seq[i]) push_byte(seq[i]);
    next_bs = 1'b1;
    seq = '{8'h07, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00};
    foreach (seq[i]) push_byte(seq[i]);
    wait_idle();
  endtask

  task automatic test_default_config();
    set_config(BLK_BYTES_RST, ENTRY_LIMIT_RST);
    run_traffic(100, 6);
    wait_idle();
    run_traffic(70, 6);
    wait_idle();
  endtask

  task automatic test_smallest_block();
    set_config(1024, 3);
    run_traffic(140, 3);
    wait_idle();
  endtask

  task automatic test_largest_block();
    set_config(65536, 1);
    run_traffic(100, 2);
    wait_idle();
  endtask

  task automatic test_short_blocks();
    set_config(40, 16383);
    run_traffic(120, 6);
    wait_idle();
  endtask

  task automatic test_zero_limits();
    set_config(0, 0);
    run_traffic(15, 2);
    wait_idle();
    set_config(1024, 0);
    run_traffic(45, 2);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    set_config(BLK_BYTES_RST, ENTRY_LIMIT_RST);
    hold_asks <= hold_asks + 1;
    no_gaps = 1'b1;
    run_traffic(150, 6);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  initial begin
    blk_size  = BLK_BYTES_RST;
    max_ent   = ENTRY_LIMIT_RST;
    ovf       = 1'b0;
    n_entries = '0;
    open_block();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_parse();
    test_default_config();
    test_smallest_block();
    test_largest_block();
    test_short_blocks();
    test_zero_limits();
    test_output_backpressure();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dep_pkg.sv
rtl/dep_parse.sv
rtl/directory_entry_parser_top.sv
bench/tb.sv
